/* hw/rtl/assert_macros.svh */
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every edge outside reset
`define VQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked every edge, reset included
`define VQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/vq_pkg.sv */
// types, constants and helper functions of the vq block decoder
`timescale 1ns / 1ps
package vq_pkg;

    localparam int MAX_CODEWORDS   = 256;
    localparam int MAX_BLOCK_ELEMS = 64;
    localparam int MAX_IMAGE_DIM   = 4096;

    localparam int BLK_W      = 4;
    localparam int WIDTH_W    = 13;
    localparam int COORD_W    = 12;
    localparam int PIX_W      = 8;
    localparam int IDX_W      = 8;
    localparam int POS_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int TAB_DEPTH  = 256;

    localparam logic [BLK_W-1:0]   BLK_MAX        = 4'd8;
    localparam logic [WIDTH_W-1:0] IMG_WIDTH_MAX  = 13'd4096;
    localparam logic [BLK_W-1:0]   BLOCK_ROWS_RST = 4'd4;
    localparam logic [BLK_W-1:0]   BLOCK_COLS_RST = 4'd4;
    localparam logic [WIDTH_W-1:0] IMG_WIDTH_RST  = 13'd256;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef enum logic [0:0] {
        MODE_LOAD,
        MODE_DECODE
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_ROWS  = 2'd0,
        CFG_BLOCK_COLS  = 2'd1,
        CFG_IMAGE_WIDTH = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic load_wr;
        logic start;
        logic issue;
    } t_ctrl_cmd;

    typedef struct packed {
        logic can_issue;
        logic last_elem;
    } t_dp_status;

    typedef int t_mod_tab [TAB_DEPTH];

    // residue table built by counting, evaluated at elaboration
    function automatic t_mod_tab mod_table(input int modulus);
        t_mod_tab tab;
        int       cnt;
        cnt = 0;
        for (int i = 0; i < TAB_DEPTH; i++) begin
            tab[i] = cnt;
            if (cnt == modulus - 1) begin
                cnt = 0;
            end else begin
                cnt = cnt + 1;
            end
        end
        return tab;
    endfunction

    function automatic logic [BLK_W-1:0] clamp_blk(input logic [BLK_W-1:0] v);
        logic [BLK_W-1:0] res;
        if (v == '0) begin
            res = 4'd1;
        end else if (v > BLK_MAX) begin
            res = BLK_MAX;
        end else begin
            res = v;
        end
        return res;
    endfunction

    function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] v);
        logic [WIDTH_W-1:0] res;
        if (v == '0) begin
            res = 13'd1;
        end else if (v > IMG_WIDTH_MAX) begin
            res = IMG_WIDTH_MAX;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

/* hw/rtl/vq_in_if.sv */
// request channel of the vq block decoder
`timescale 1ns / 1ps
interface vq_in_if;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [vq_pkg::IDX_W-1:0]   codeword_index;
    logic [vq_pkg::POS_W-1:0]   element_pos;
    logic [vq_pkg::PIX_W-1:0]   element_value;

    modport source (
        output valid, mode, codeword_index, element_pos, element_value,
        input  ready
    );
    modport sink (
        input  valid, mode, codeword_index, element_pos, element_value,
        output ready
    );
endinterface

/* hw/rtl/vq_out_if.sv */
// pixel channel of the vq block decoder
`timescale 1ns / 1ps
interface vq_out_if;
    logic                         valid;
    logic                         ready;
    logic [vq_pkg::PIX_W-1:0]     pixel_value;
    logic [vq_pkg::COORD_W-1:0]   pixel_row;
    logic [vq_pkg::COORD_W-1:0]   pixel_col;
    logic                         last_of_block;

    modport source (
        output valid, pixel_value, pixel_row, pixel_col, last_of_block,
        input  ready
    );
    modport sink (
        input  valid, pixel_value, pixel_row, pixel_col, last_of_block,
        output ready
    );
endinterface

/* hw/rtl/vq_ram.sv */
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
module vq_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* hw/rtl/vq_ctrl.sv */
// request sequencing state machine of the vq block decoder
`timescale 1ns / 1ps
module vq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_mode,
    output logic               o_in_ready,
    input  vq_pkg::t_dp_status i_status,
    output vq_pkg::t_ctrl_cmd  o_cmd
);
    vq_pkg::t_state    r_state;
    vq_pkg::t_state    n_state;
    vq_pkg::t_ctrl_cmd cmd;
    logic              in_ready;
    logic              accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        case (r_state)
            vq_pkg::ST_IDLE: begin
                in_ready = 1'b1;
            end
            vq_pkg::ST_RUN: begin
                cmd.issue = i_status.can_issue;
                // next request may enter as the final read goes out
                in_ready  = i_status.can_issue && i_status.last_elem;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase

        accept      = in_ready && i_in_valid;
        cmd.load_wr = accept && (i_in_mode == vq_pkg::MODE_LOAD);
        cmd.start   = accept && (i_in_mode == vq_pkg::MODE_DECODE);

        n_state = r_state;
        if (cmd.start) begin
            n_state = vq_pkg::ST_RUN;
        end else if (cmd.issue && i_status.last_elem) begin
            n_state = vq_pkg::ST_IDLE;
        end else if (r_state != vq_pkg::ST_RUN) begin
            n_state = vq_pkg::ST_IDLE;
        end
    end

    assign o_in_ready = in_ready;
    assign o_cmd      = cmd;
endmodule

/* hw/rtl/vq_dp.sv */
// codebook store, block counters, cursor and pixel output stages
`timescale 1ns / 1ps
module vq_dp #(
    parameter int MAX_CODEWORDS   = vq_pkg::MAX_CODEWORDS,
    parameter int MAX_BLOCK_ELEMS = vq_pkg::MAX_BLOCK_ELEMS,
    parameter int MAX_IMAGE_DIM   = vq_pkg::MAX_IMAGE_DIM
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  vq_pkg::t_ctrl_cmd                i_cmd,
    output vq_pkg::t_dp_status               o_status,
    input  logic                             i_cfg_wr_en,
    input  logic [vq_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [vq_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic [vq_pkg::IDX_W-1:0]         i_codeword_index,
    input  logic [vq_pkg::POS_W-1:0]         i_element_pos,
    input  logic [vq_pkg::PIX_W-1:0]         i_element_value,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [vq_pkg::PIX_W-1:0]         o_pixel_value,
    output logic [vq_pkg::COORD_W-1:0]       o_pixel_row,
    output logic [vq_pkg::COORD_W-1:0]       o_pixel_col,
    output logic                             o_last_of_block
);
    localparam int CW_W   = (MAX_CODEWORDS > 1) ? $clog2(MAX_CODEWORDS) : 1;
    localparam int PW     = (MAX_BLOCK_ELEMS > 1) ? $clog2(MAX_BLOCK_ELEMS) : 1;
    localparam int DEPTH  = MAX_CODEWORDS * MAX_BLOCK_ELEMS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CDW    = vq_pkg::COORD_W;
    localparam int RW     = ($clog2(MAX_IMAGE_DIM) + 1 > CDW + 1) ?
                            $clog2(MAX_IMAGE_DIM) + 1 : CDW + 1;
    localparam int TAB_AW = $clog2(vq_pkg::TAB_DEPTH);

    localparam vq_pkg::t_mod_tab IDX_TAB = vq_pkg::mod_table(MAX_CODEWORDS);
    localparam vq_pkg::t_mod_tab POS_TAB = vq_pkg::mod_table(MAX_BLOCK_ELEMS);

    // one conditional subtract suffices: the sum stays below twice the limit
    function automatic logic [CDW-1:0] row_wrap(input logic [CDW:0] x);
        logic [RW-1:0] xe;
        xe = RW'(x);
        if (xe >= RW'(MAX_IMAGE_DIM)) begin
            xe = xe - RW'(MAX_IMAGE_DIM);
        end
        return xe[CDW-1:0];
    endfunction

    logic [vq_pkg::BLK_W-1:0]   r_block_rows;
    logic [vq_pkg::BLK_W-1:0]   r_block_cols;
    logic [vq_pkg::WIDTH_W-1:0] r_image_width;
    logic [vq_pkg::BLK_W-1:0]   blk_rows;
    logic [vq_pkg::BLK_W-1:0]   blk_cols;
    logic [vq_pkg::WIDTH_W-1:0] img_width;

    logic [CW_W-1:0] r_idx;
    logic [2:0]      r_j;
    logic [2:0]      r_k;
    logic [PW-1:0]   r_pos;
    logic [CDW-1:0]  r_cur_row;
    logic [CDW-1:0]  r_cur_col;

    logic            r_s1_v;
    logic [CDW-1:0]  r_s1_row;
    logic [CDW-1:0]  r_s1_col;
    logic            r_s1_last;

    logic                     r_o_v;
    logic [vq_pkg::PIX_W-1:0] r_o_value;
    logic [CDW-1:0]           r_o_row;
    logic [CDW-1:0]           r_o_col;
    logic                     r_o_last;

    logic [CW_W-1:0]            wr_idx;
    logic [PW-1:0]              wr_pos;
    logic [AW-1:0]              wr_addr;
    logic [AW-1:0]              rd_addr;
    logic [vq_pkg::PIX_W-1:0]   ram_rdata;
    logic                       last_elem;
    logic                       out_free;
    logic                       s1_move;
    logic                       can_issue;
    logic [CDW-1:0]             pix_row;
    logic [CDW-1:0]             pix_col;
    logic [CDW-1:0]             n_cur_col;
    logic [CDW:0]               wrap_sum;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_rows  <= vq_pkg::BLOCK_ROWS_RST;
            r_block_cols  <= vq_pkg::BLOCK_COLS_RST;
            r_image_width <= vq_pkg::IMG_WIDTH_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                vq_pkg::CFG_BLOCK_ROWS: begin
                    r_block_rows <= i_cfg_wdata[vq_pkg::BLK_W-1:0];
                end
                vq_pkg::CFG_BLOCK_COLS: begin
                    r_block_cols <= i_cfg_wdata[vq_pkg::BLK_W-1:0];
                end
                vq_pkg::CFG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_wdata[vq_pkg::WIDTH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign blk_rows  = vq_pkg::clamp_blk(r_block_rows);
    assign blk_cols  = vq_pkg::clamp_blk(r_block_cols);
    assign img_width = vq_pkg::clamp_width(r_image_width);

    // codebook addressing: entry index times entry size plus position
    assign wr_idx  = CW_W'(IDX_TAB[i_codeword_index]);
    assign wr_pos  = PW'(POS_TAB[TAB_AW'(i_element_pos)]);
    assign wr_addr = AW'(wr_idx) * AW'(MAX_BLOCK_ELEMS) + AW'(wr_pos);
    assign rd_addr = AW'(r_idx) * AW'(MAX_BLOCK_ELEMS) + AW'(r_pos);

    vq_ram #(
        .WIDTH (vq_pkg::PIX_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_wr),
        .i_waddr (wr_addr),
        .i_wdata (i_element_value),
        .i_re    (i_cmd.issue),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    assign last_elem = (4'(r_j) == blk_rows - 4'd1) && (4'(r_k) == blk_cols - 4'd1);
    assign out_free  = !r_o_v || i_out_ready;
    assign s1_move   = r_s1_v && out_free;
    // ram read data holds while the stage behind it is stalled
    assign can_issue = !r_s1_v || s1_move;

    assign o_status.can_issue = can_issue;
    assign o_status.last_elem = last_elem;

    assign pix_row = row_wrap((CDW + 1)'(r_cur_row) + (CDW + 1)'(r_j));
    assign pix_col = r_cur_col + CDW'(r_k);

    assign n_cur_col = r_cur_col + CDW'(blk_cols);
    assign wrap_sum  = (CDW + 1)'(n_cur_col) + (CDW + 1)'(blk_cols);

    // block counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_idx <= CW_W'(IDX_TAB[i_codeword_index]);
            r_j   <= '0;
            r_k   <= '0;
            r_pos <= '0;
        end else if (i_cmd.issue) begin
            if (4'(r_k) == blk_cols - 4'd1) begin
                r_k <= '0;
                r_j <= r_j + 3'd1;
            end else begin
                r_k <= r_k + 3'd1;
            end
            if (r_pos == PW'(MAX_BLOCK_ELEMS - 1)) begin
                r_pos <= '0;
            end else begin
                r_pos <= r_pos + PW'(1);
            end
        end
    end

    // block cursor moves on once the final read of a block goes out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_row <= '0;
            r_cur_col <= '0;
        end else if (i_cmd.issue && last_elem) begin
            if (wrap_sum > (CDW + 1)'(img_width)) begin
                r_cur_col <= '0;
                r_cur_row <= row_wrap((CDW + 1)'(r_cur_row) + (CDW + 1)'(blk_rows));
            end else begin
                r_cur_col <= n_cur_col;
            end
        end
    end

    // read stage and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            if (i_cmd.issue) begin
                r_s1_v <= 1'b1;
            end else if (s1_move) begin
                r_s1_v <= 1'b0;
            end
            if (s1_move) begin
                r_o_v <= 1'b1;
            end else if (i_out_ready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_s1_row  <= pix_row;
            r_s1_col  <= pix_col;
            r_s1_last <= last_elem;
        end
        if (s1_move) begin
            r_o_value <= ram_rdata;
            r_o_row   <= r_s1_row;
            r_o_col   <= r_s1_col;
            r_o_last  <= r_s1_last;
        end
    end

    assign o_out_valid     = r_o_v;
    assign o_pixel_value   = r_o_value;
    assign o_pixel_row     = r_o_row;
    assign o_pixel_col     = r_o_col;
    assign o_last_of_block = r_o_last;
endmodule

/* hw/rtl/vq_block_decoder.sv */
// top level of the vq block decoder
//
//  channel   dir  carries                                       moves on
//  i_req     in   mode, codeword_index, element_pos, value      valid && ready
//  o_pix     out  pixel_value, pixel_row, pixel_col, last       valid && ready
//  i_cfg_*   in   register index and write data                 i_cfg_wr_en
//
// a load request writes its byte into the ram; a decode request reads one codebook
// byte per cycle from the single ram read port unless the output stalls, holds the
// request side to its final read; pixels pass the read stage and output register.
// synchronous active-low reset clears the state machine, cursor, config and valids.
// output stalls back up through the read stage and halt the reads, nothing is lost.
`timescale 1ns / 1ps
module vq_block_decoder #(
    parameter int MAX_CODEWORDS   = vq_pkg::MAX_CODEWORDS,
    parameter int MAX_BLOCK_ELEMS = vq_pkg::MAX_BLOCK_ELEMS,
    parameter int MAX_IMAGE_DIM   = vq_pkg::MAX_IMAGE_DIM
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [vq_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [vq_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    vq_in_if.sink                         i_req,
    vq_out_if.source                      o_pix
);
    vq_pkg::t_ctrl_cmd  cmd;
    vq_pkg::t_dp_status status;

    vq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_in_mode  (i_req.mode),
        .o_in_ready (i_req.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    vq_dp #(
        .MAX_CODEWORDS   (MAX_CODEWORDS),
        .MAX_BLOCK_ELEMS (MAX_BLOCK_ELEMS),
        .MAX_IMAGE_DIM   (MAX_IMAGE_DIM)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_codeword_index (i_req.codeword_index),
        .i_element_pos    (i_req.element_pos),
        .i_element_value  (i_req.element_value),
        .i_out_ready      (o_pix.ready),
        .o_out_valid      (o_pix.valid),
        .o_pixel_value    (o_pix.pixel_value),
        .o_pixel_row      (o_pix.pixel_row),
        .o_pixel_col      (o_pix.pixel_col),
        .o_last_of_block  (o_pix.last_of_block)
    );
endmodule

/* hw/rtl/vq_chk.sv */
// port-level assertion checker for the vq block decoder, with its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vq_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_req_ready,
    input logic                          i_pix_valid,
    input logic                          i_pix_ready,
    input logic [vq_pkg::PIX_W-1:0]      i_pix_value,
    input logic [vq_pkg::COORD_W-1:0]    i_pix_row,
    input logic [vq_pkg::COORD_W-1:0]    i_pix_col,
    input logic                          i_pix_last
);
    `VQ_ASSERT_ALWAYS(a_rst_no_pixel, i_clk, !i_rst_n |=> !i_pix_valid,
        "pixel valid after reset")
    `VQ_ASSERT_ALWAYS(a_rst_ready, i_clk, !i_rst_n |=> i_req_ready,
        "request side not ready after reset")
    `VQ_ASSERT(a_pix_hold, i_clk, i_rst_n,
        i_pix_valid && !i_pix_ready |=> i_pix_valid && $stable(i_pix_value) &&
        $stable(i_pix_row) && $stable(i_pix_col) && $stable(i_pix_last),
        "stalled pixel changed")
endmodule

bind vq_block_decoder vq_chk u_vq_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_ready (i_req.ready),
    .i_pix_valid (o_pix.valid),
    .i_pix_ready (o_pix.ready),
    .i_pix_value (o_pix.pixel_value),
    .i_pix_row   (o_pix.pixel_row),
    .i_pix_col   (o_pix.pixel_col),
    .i_pix_last  (o_pix.last_of_block)
);

/* tb/vq_block_decoder_tb.sv */
// testbench for the vq block decoder: codebook loads, block decodes and cursor walks
`timescale 1ns / 1ps
module vq_block_decoder_tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_ITEMS   = 60;
    localparam int TAIL_ITEMS    = 12;
    localparam int DIR_N         = 29;
    localparam int STORE_N       = vq_pkg::MAX_CODEWORDS * vq_pkg::MAX_BLOCK_ELEMS;

    localparam vq_pkg::t_mode    M_LD    = vq_pkg::MODE_LOAD;
    localparam vq_pkg::t_mode    M_DC    = vq_pkg::MODE_DECODE;
    localparam vq_pkg::t_cfg_reg R_ROWS  = vq_pkg::CFG_BLOCK_ROWS;
    localparam vq_pkg::t_cfg_reg R_COLS  = vq_pkg::CFG_BLOCK_COLS;
    localparam vq_pkg::t_cfg_reg R_WIDTH = vq_pkg::CFG_IMAGE_WIDTH;

    typedef struct packed {
        logic [vq_pkg::PIX_W-1:0]   pixel_value;
        logic [vq_pkg::COORD_W-1:0] pixel_row;
        logic [vq_pkg::COORD_W-1:0] pixel_col;
        logic                       last_of_block;
    } t_pixel;

    typedef struct packed {
        logic                          is_cfg;
        vq_pkg::t_cfg_reg              cfg_sel;
        logic [vq_pkg::CFG_DATA_W-1:0] cfg_data;
        vq_pkg::t_mode                 mode;
        logic [vq_pkg::IDX_W-1:0]      idx;
        logic [vq_pkg::POS_W-1:0]      pos;
        logic [vq_pkg::PIX_W-1:0]      val;
        logic                          typed;
        t_pixel                        typed_pix;
    } t_step;

    // register writes, loads and decodes; typed pixels only on 1x1 blocks
    localparam t_step DIR_STEPS [DIR_N] = '{
        '{1'b1, R_ROWS,  13'd0,    M_LD, 8'd0,   6'd0,  8'h00, 1'b0, '0},
        '{1'b1, R_COLS,  13'd1,    M_LD, 8'd0,   6'd0,  8'h00, 1'b0, '0},
        '{1'b0, R_ROWS,  13'd0,    M_LD, 8'd0,   6'd0,  8'hA5, 1'b0, '0},
        '{1'b0, R_ROWS,  13'd0,    M_LD, 8'd255, 6'd63, 8'hFF, 1'b0, '0},
        '{1'b0, R_ROWS,  13'd0,    M_LD, 8'd255, 6'd0,  8'h00, 1'b0, '0},
        '{1'b0, R_ROWS,  13'd0,    M_DC, 8'd0,   6'd0,  8'h00, 1'b1,
          '{8'hA5, 12'd0, 12'd0, 1'b1}},
        '{1'b0, R_ROWS,  13'd0,    M_DC, 8'd255, 6'd0,  8'h00, 1'b1,
          '{8'h00, 12'd0, 12'd1, 1'b1}},
        '{1'b1, R_WIDTH, 13'd0,    M_LD, 8'd0,   6'd0,  8'h00, 1'b0, '0},
        '{1'b0, R_ROWS,  13'd0,    M_DC, 8'd0,   6'd0,  8'h00, 1'b1,
          '{8'hA5, 12'd0, 12'd2, 1'b1}},
        '{1'b0, R_ROWS,  13'd0,    M_DC, 8'd255, 6'd0,  8'h00, 1'b1,
          '{8'h00, 12'd1, 12'd0, 1'b1}},
        '{1'b1, R_WIDTH, 13'h1FFF, M_LD, 8'd0,   6'd0,  8'h00, 1'b0, '0},
        '{1'b1, R_COLS,  13'd15,   M_LD, 8'd0,   6'd0,  8'h00, 1'b0, '0},
        '{1'b0, R_ROWS,  13'd0,    M_LD, 8'd255, 6'd1,  8'h01, 1'b0, '0},
        '{1'b0, R_ROWS,  13'd0,    M_LD, 8'd255, 6'd2,  8'h02, 1'b0, '0},
        '{1'b0, R_ROWS,  13'd0,    M_LD, 8'd255, 6'd3,  8'h04, 1'b0, '0},
        '{1'b0, R_ROWS,  13'd0,    M_LD, 8'd255, 6'd4,  8'h08, 1'b0, '0},
        '{1'b0, R_ROWS,  13'd0,    M_LD, 8'd255, 6'd5,  8'h10, 1'b0, '0},
        '{1'b0, R_ROWS,  13'd0,    M_LD, 8'd255, 6'd6,  8'h20, 1'b0, '0},
        '{1'b0, R_ROWS,  13'd0,    M_LD, 8'd255, 6'd7,  8'h40, 1'b0, '0},
        '{1'b0, R_ROWS,  13'd0,    M_DC, 8'd255, 6'd0,  8'h00, 1'b0, '0},
        '{1'b1, R_ROWS,  13'd15,   M_LD, 8'd0,   6'd0,  8'h00, 1'b0, '0},
        '{1'b1, R_COLS,  13'd1,    M_LD, 8'd0,   6'd0,  8'h00, 1'b0, '0},
        '{1'b0, R_ROWS,  13'd0,    M_DC, 8'd255, 6'd0,  8'h00, 1'b0, '0},
        '{1'b0, R_ROWS,  13'd0,    M_LD, 8'd170, 6'd42, 8'h5A, 1'b0, '0},
        '{1'b1, R_WIDTH, 13'd4,    M_LD, 8'd0,   6'd0,  8'h00, 1'b0, '0},
        '{1'b1, R_COLS,  13'd8,    M_LD, 8'd0,   6'd0,  8'h00, 1'b0, '0},
        '{1'b1, R_ROWS,  13'd1,    M_LD, 8'd0,   6'd0,  8'h00, 1'b0, '0},
        '{1'b0, R_ROWS,  13'd0,    M_DC, 8'd255, 6'd0,  8'h00, 1'b0, '0},
        '{1'b0, R_ROWS,  13'd0,    M_DC, 8'd255, 6'd0,  8'h00, 1'b0, '0}
    };

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_wr_en;
    logic [vq_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [vq_pkg::CFG_DATA_W-1:0] i_cfg_wdata;

    vq_in_if  req_if ();
    vq_out_if pix_if ();

    vq_block_decoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_pix       (pix_if)
    );

    // mirror of the block's state
    logic [vq_pkg::PIX_W-1:0]   codebook_copy [STORE_N];
    bit                         byte_loaded   [STORE_N];
    int                         entry_prefix  [vq_pkg::MAX_CODEWORDS];
    logic [vq_pkg::BLK_W-1:0]   rows_reg;
    logic [vq_pkg::BLK_W-1:0]   cols_reg;
    logic [vq_pkg::WIDTH_W-1:0] width_reg;
    logic [vq_pkg::COORD_W-1:0] cursor_row;
    logic [vq_pkg::COORD_W-1:0] cursor_col;

    t_pixel pending_pixels [$];

    int req_gap_pct;
    int pix_stall_pct;
    int fill_entry;
    int n_loads;
    int n_decodes;
    int n_pixels_seen;
    int row_wraps;
    int mismatches;
    int cycle_count;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int sat_dim(input int v, input int hi);
        return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    function automatic int block_area();
        return sat_dim(rows_reg, vq_pkg::BLK_MAX) * sat_dim(cols_reg, vq_pkg::BLK_MAX);
    endfunction

    // expected pixels and cursor update of a decode, codebook copy update of a load
    function automatic void apply_request(input vq_pkg::t_mode m,
                                          input logic [vq_pkg::IDX_W-1:0] idx,
                                          input logic [vq_pkg::POS_W-1:0] pos,
                                          input logic [vq_pkg::PIX_W-1:0] val,
                                          input bit typed, input t_pixel typed_pix);
        int                         base;
        int                         nr;
        int                         nc;
        int                         nw;
        int                         n;
        t_pixel                     px;
        logic [vq_pkg::COORD_W-1:0] next_col;
        logic [vq_pkg::COORD_W-1:0] old_row;
        base = int'(idx) * vq_pkg::MAX_BLOCK_ELEMS;
        if (m == vq_pkg::MODE_LOAD) begin
            n_loads++;
            codebook_copy[base + pos] = val;
            byte_loaded[base + pos] = 1'b1;
            while (entry_prefix[idx] < vq_pkg::MAX_BLOCK_ELEMS &&
                   byte_loaded[base + entry_prefix[idx]])
                entry_prefix[idx]++;
            return;
        end
        n_decodes++;
        nr = sat_dim(rows_reg, vq_pkg::BLK_MAX);
        nc = sat_dim(cols_reg, vq_pkg::BLK_MAX);
        nw = sat_dim(width_reg, vq_pkg::IMG_WIDTH_MAX);
        n = 0;
        for (int j = 0; j < nr; j++) begin
            for (int k = 0; k < nc; k++) begin
                px.pixel_value   = codebook_copy[base + n % vq_pkg::MAX_BLOCK_ELEMS];
                px.pixel_row     = 12'(cursor_row + j);
                px.pixel_col     = 12'(cursor_col + k);
                px.last_of_block = (j == nr - 1) && (k == nc - 1);
                if (typed && n == 0) begin
                    px = typed_pix;
                end
                pending_pixels.push_back(px);
                n++;
            end
        end
        next_col = 12'(cursor_col + nc);
        if (int'(next_col) + nc > nw) begin
            cursor_col = '0;
            old_row = cursor_row;
            cursor_row = 12'(cursor_row + nr);
            if (cursor_row < old_row) begin
                row_wraps++;
            end
        end else begin
            cursor_col = next_col;
        end
    endfunction

    function automatic void check_pixel(input t_pixel got);
        t_pixel want;
        n_pixels_seen++;
        if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected pixel v=%h row=%0d col=%0d last=%b",
                         got.pixel_value, got.pixel_row, got.pixel_col, got.last_of_block);
            return;
        end
        want = pending_pixels.pop_front();
        if (got.pixel_value !== want.pixel_value || got.pixel_row !== want.pixel_row ||
            got.pixel_col !== want.pixel_col || got.last_of_block !== want.last_of_block) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"pixel %0d: expected v=%h row=%0d col=%0d last=%b, ",
                          "got v=%h row=%0d col=%0d last=%b"},
                         n_pixels_seen, want.pixel_value, want.pixel_row, want.pixel_col,
                         want.last_of_block, got.pixel_value, got.pixel_row, got.pixel_col,
                         got.last_of_block);
        end
    endfunction

    // pixel sink with random back-pressure
    always @(posedge i_clk) begin
        if (i_rst_n && pix_if.valid === 1'b1 && pix_if.ready === 1'b1)
            check_pixel({pix_if.pixel_value, pix_if.pixel_row, pix_if.pixel_col,
                         pix_if.last_of_block});
        pix_if.ready <= ($urandom_range(99) >= pix_stall_pct);
    end

    task automatic send_req(input vq_pkg::t_mode m, input logic [vq_pkg::IDX_W-1:0] idx,
                            input logic [vq_pkg::POS_W-1:0] pos,
                            input logic [vq_pkg::PIX_W-1:0] val,
                            input bit typed, input t_pixel typed_pix);
        if (req_gap_pct != 0 && $urandom_range(99) < req_gap_pct) begin
            req_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < req_gap_pct);
        end
        req_if.valid          <= 1'b1;
        req_if.mode           <= m;
        req_if.codeword_index <= idx;
        req_if.element_pos    <= pos;
        req_if.element_value  <= val;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1) @(posedge i_clk);
        apply_request(m, idx, pos, val, typed, typed_pix);
    endtask

    task automatic write_reg(input vq_pkg::t_cfg_reg sel,
                             input logic [vq_pkg::CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= sel;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (sel)
            vq_pkg::CFG_BLOCK_ROWS:  rows_reg  = data[vq_pkg::BLK_W-1:0];
            vq_pkg::CFG_BLOCK_COLS:  cols_reg  = data[vq_pkg::BLK_W-1:0];
            vq_pkg::CFG_IMAGE_WIDTH: width_reg = data[vq_pkg::WIDTH_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // all pixels back, then a settle wait so that a trailing load can retire
    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mostly well-formed: fill an entry byte by byte, decode entries already filled
    task automatic random_request(input int noise_pct, input int fill_pct);
        int need;
        int roll;
        int filled [$];
        need = block_area();
        for (int e = 0; e < vq_pkg::MAX_CODEWORDS; e++) begin
            if (entry_prefix[e] >= need)
                filled.push_back(e);
        end
        roll = $urandom_range(99);
        if (roll < noise_pct) begin
            send_req(M_LD, 8'($urandom_range(255)), 6'($urandom_range(63)),
                     8'($urandom_range(255)), 1'b0, '0);
        end else if (filled.size() == 0 || roll < noise_pct + fill_pct) begin
            if (entry_prefix[fill_entry] >= need)
                fill_entry = $urandom_range(vq_pkg::MAX_CODEWORDS - 1);
            send_req(M_LD, 8'(fill_entry), 6'(entry_prefix[fill_entry]),
                     8'($urandom_range(255)), 1'b0, '0);
        end else begin
            send_req(M_DC, 8'(filled[$urandom_range(filled.size() - 1)]),
                     6'($urandom_range(63)), 8'($urandom_range(255)), 1'b0, '0);
        end
    endtask

    task automatic set_geometry(input int phase);
        wait_idle();
        case (phase)
            0: begin
                write_reg(R_ROWS, 13'd8);
                write_reg(R_COLS, 13'd8);
                write_reg(R_WIDTH, 13'($urandom_range(64, 8)));
            end
            1, 5: begin
                // upper data bits are random, block size saturates
                write_reg(R_ROWS, 13'($urandom_range(8191)));
                write_reg(R_COLS, 13'($urandom_range(8191)));
                write_reg(R_WIDTH, 13'($urandom_range(32, 1)));
            end
            2: begin
                write_reg(R_ROWS, 13'd1);
                write_reg(R_COLS, 13'd1);
                write_reg(R_WIDTH, 13'($urandom_range(3, 1)));
            end
            3: begin
                write_reg(R_ROWS, 13'd0);
                write_reg(R_COLS, 13'd15);
                write_reg(R_WIDTH, 13'h1FFF);
            end
            default: begin
                write_reg(R_ROWS, 13'($urandom_range(8, 1)));
                write_reg(R_COLS, 13'($urandom_range(8, 1)));
                write_reg(R_WIDTH, 13'($urandom_range(4096, 1)));
            end
        endcase
    endtask

    initial begin
        i_rst_n              = 1'b0;
        i_cfg_wr_en          = 1'b0;
        i_cfg_idx            = vq_pkg::CFG_BLOCK_ROWS;
        i_cfg_wdata          = '0;
        req_if.valid         = 1'b0;
        req_if.mode          = vq_pkg::MODE_LOAD;
        req_if.codeword_index = '0;
        req_if.element_pos   = '0;
        req_if.element_value = '0;
        pix_if.ready         = 1'b0;
        rows_reg             = vq_pkg::BLOCK_ROWS_RST;
        cols_reg             = vq_pkg::BLOCK_COLS_RST;
        width_reg            = vq_pkg::IMG_WIDTH_RST;
        cursor_row           = '0;
        cursor_col           = '0;
        cycle_count          = 0;
        fill_entry           = 0;
        n_loads              = 0;
        n_decodes            = 0;
        n_pixels_seen        = 0;
        row_wraps            = 0;
        mismatches           = 0;
        foreach (entry_prefix[e]) entry_prefix[e] = 0;
        foreach (byte_loaded[b]) byte_loaded[b] = 1'b0;
        req_gap_pct   = 9;
        pix_stall_pct = 55;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_N; i++) begin
            if (DIR_STEPS[i].is_cfg) begin
                wait_idle();
                write_reg(DIR_STEPS[i].cfg_sel, DIR_STEPS[i].cfg_data);
            end else begin
                send_req(DIR_STEPS[i].mode, DIR_STEPS[i].idx, DIR_STEPS[i].pos,
                         DIR_STEPS[i].val, DIR_STEPS[i].typed, DIR_STEPS[i].typed_pix);
            end
        end

        for (int p = 0; p < 6; p++) begin
            if (p == 2) begin
                req_gap_pct   = 55;
                pix_stall_pct = 9;
            end else if (p == 4) begin
                req_gap_pct   = 0;
                pix_stall_pct = 0;
            end
            set_geometry(p);
            repeat (PHASE_ITEMS) random_request(12, 25);
        end

        // tall blocks on a one-pixel-wide image, every block moves down
        wait_idle();
        write_reg(R_ROWS, 13'd8);
        write_reg(R_COLS, 13'd1);
        write_reg(R_WIDTH, 13'd1);
        repeat (TAIL_ITEMS) random_request(0, 0);

        // wide blocks across a full-width image
        wait_idle();
        write_reg(R_ROWS, 13'd1);
        write_reg(R_COLS, 13'd8);
        write_reg(R_WIDTH, 13'd4096);
        repeat (TAIL_ITEMS) random_request(0, 0);

        wait_idle();
        $display("run covered %0d codebook loads and %0d block decodes, %0d pixels compared",
                 n_loads, n_decodes, n_pixels_seen);
        $display("block sizes 1x1 to 8x8, saturated registers, row cursor wrapped %0d time(s)",
                 row_wraps);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
